/* rtl/core/ccfc_pkg.sv */
package ccfc_pkg;

  // Frame delimiters and command letters.
  localparam logic [7:0] CH_START  = 8'h24;  // '$'
  localparam logic [7:0] CH_END    = 8'h23;  // '#'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_FOUR   = 8'h34;
  localparam logic [7:0] CH_SIX    = 8'h36;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_S      = 8'h53;

  // Limit settings that a LIM command may request, in amps.
  localparam logic [4:0] AMPS_0  = 5'd0;
  localparam logic [4:0] AMPS_8  = 5'd8;
  localparam logic [4:0] AMPS_16 = 5'd16;
  localparam logic [4:0] AMPS_24 = 5'd24;

  typedef enum logic [2:0] {
    LIFE_WAITING = 3'b001,
    LIFE_ACTIVE  = 3'b010,
    LIFE_ENDED   = 3'b100
  } life_t;

  // Encoded lifecycle as reported on the result channel.
  localparam logic [1:0] LC_WAITING = 2'd0;
  localparam logic [1:0] LC_ACTIVE  = 2'd1;
  localparam logic [1:0] LC_ENDED   = 2'd2;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_CON  = 2'd1,
    PEND_DIS  = 2'd2,
    PEND_LIM  = 2'd3
  } pend_t;

  localparam logic [1:0] REPORT_NONE   = 2'd0;
  localparam logic [1:0] REPORT_ACK    = 2'd1;
  localparam logic [1:0] REPORT_STATUS = 2'd2;

  localparam logic [1:0] ACK_GO   = 2'd0;
  localparam logic [1:0] ACK_CON  = 2'd1;
  localparam logic [1:0] ACK_DIS  = 2'd2;
  localparam logic [1:0] ACK_LIM  = 2'd3;

  localparam logic CMD_BYTE = 1'b0;

endpackage

/* rtl/core/charger_command_frame_controller.sv */
// Charger command frame controller.
// The item channel (item_valid/item_ready) carries one beat per received
// serial byte (cmd 0) or per 100 ms tick (cmd 1), together with the latest
// sensor reading, thermal band character and thermal current cap.
// Bytes are assembled into '$' body '#' frames; GO, END, CONn, DISn and
// LIMdd are decoded when the closing '#' arrives. In-run commands are held
// until the next tick of the active phase, which applies them and reports
// either an acknowledge or a status beat.
// The result channel (result_valid/result_ready) returns exactly one beat
// for every accepted item, including beats whose report_kind is zero.
// The result of an item is registered at the edge that accepts it. Throughput
// is one item per cycle while the receiver takes each result; all decode work
// is a single pass of logic between the accepted beat and the result register.
// If the receiver stalls, the result register holds its beat and
// item_ready stays low until it is taken; a beat is accepted in the same
// cycle that the waiting result is taken.
// Reset puts the lifecycle in waiting, clears the port mask, the pending
// command, the requested limit and the frame assembler, and empties the
// result register. Body bytes need no reset.
module charger_command_frame_controller #(
  parameter int BODY_MAX          = 8,
  parameter int CONVERSION_PERIOD = 5
) (
  input  logic       clk,
  input  logic       rst,

  input  logic       item_valid,
  output logic       item_ready,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  input  logic       rx_frame_error,
  input  logic [9:0] sensor_reading,
  input  logic [7:0] thermal_band_char,
  input  logic [4:0] thermal_limit_cap,

  output logic       result_valid,
  input  logic       result_ready,
  output logic [1:0] report_kind,
  output logic [1:0] ack_number,
  output logic [7:0] band_out,
  output logic [9:0] reading_out,
  output logic [2:0] ports_connected,
  output logic [4:0] effective_limit,
  output logic       start_conversion,
  output logic [1:0] lifecycle
);
  import ccfc_pkg::*;

  localparam int LEN_W = $clog2(BODY_MAX + 1);
  localparam int IDX_W = $clog2(BODY_MAX);
  localparam int DIV_W = $clog2(CONVERSION_PERIOD + 1);

  // State.
  life_t            life_state, life_state_next;
  logic [2:0]       port_mask, port_mask_next;
  pend_t            pending_kind, pending_kind_next;
  logic [4:0]       pending_value, pending_value_next;
  logic             ack_waiting, ack_waiting_next;
  logic [1:0]       ack_value, ack_value_next;
  logic [DIV_W-1:0] conversion_divider, conversion_divider_next;
  logic [4:0]       requested_amps, requested_amps_next;
  logic             in_frame, in_frame_next;
  logic [LEN_W-1:0] body_length, body_length_next;
  logic [7:0]       body_bytes [BODY_MAX];

  logic             accept;
  logic             body_write;
  logic             start_next;
  logic [1:0]       kind_next;
  logic [1:0]       ackn_next;
  logic [7:0]       band_next;
  logic [9:0]       reading_next;
  logic [4:0]       eff_next;
  logic [1:0]       life_code_next;
  logic [2:0]       port_bit;
  logic [DIV_W-1:0] div_inc;

  // Frame pattern matches on the held body.
  logic is_go, is_end, is_condis, is_lim, port_ok, lim_ok;

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;

  always_comb begin
    is_go  = (body_length == LEN_W'(2)) && body_bytes[0] == CH_G && body_bytes[1] == CH_O;
    is_end = (body_length == LEN_W'(3)) && body_bytes[0] == CH_E
             && body_bytes[1] == CH_N && body_bytes[2] == CH_D;
    is_condis = (body_length == LEN_W'(4))
                && ((body_bytes[0] == CH_C && body_bytes[1] == CH_O && body_bytes[2] == CH_N)
                 || (body_bytes[0] == CH_D && body_bytes[1] == CH_I && body_bytes[2] == CH_S));
    port_ok = (body_bytes[3] == CH_ZERO) || (body_bytes[3] == CH_ONE)
              || (body_bytes[3] == CH_TWO);
    is_lim = (body_length == LEN_W'(5)) && body_bytes[0] == CH_L
             && body_bytes[1] == CH_I && body_bytes[2] == CH_M;
    lim_ok = (body_bytes[3] == CH_ZERO && body_bytes[4] == CH_ZERO)
          || (body_bytes[3] == CH_ZERO && body_bytes[4] == CH_EIGHT)
          || (body_bytes[3] == CH_ONE  && body_bytes[4] == CH_SIX)
          || (body_bytes[3] == CH_TWO  && body_bytes[4] == CH_FOUR);
  end

  // Port bit of the pending command; an index of three selects no port.
  always_comb begin
    case (pending_value[1:0])
      2'd0:    port_bit = 3'b001;
      2'd1:    port_bit = 3'b010;
      2'd2:    port_bit = 3'b100;
      default: port_bit = 3'b000;
    endcase
  end

  assign div_inc = conversion_divider + DIV_W'(1);

  always_comb begin
    life_state_next         = life_state;
    port_mask_next          = port_mask;
    pending_kind_next       = pending_kind;
    pending_value_next      = pending_value;
    ack_waiting_next        = ack_waiting;
    ack_value_next          = ack_value;
    conversion_divider_next = conversion_divider;
    requested_amps_next     = requested_amps;
    in_frame_next           = in_frame;
    body_length_next        = body_length;
    body_write              = 1'b0;
    start_next              = 1'b0;
    kind_next               = REPORT_NONE;
    ackn_next               = ACK_GO;
    band_next               = '0;
    reading_next            = '0;

    if (cmd == CMD_BYTE) begin
      if (!rx_frame_error && life_state != LIFE_ENDED) begin
        if (rx_byte == CH_START) begin
          in_frame_next    = 1'b1;
          body_length_next = '0;
        end else if (in_frame) begin
          if (rx_byte == CH_END) begin
            in_frame_next = 1'b0;
            if (is_go) begin
              if (life_state == LIFE_WAITING) begin
                life_state_next         = LIFE_ACTIVE;
                ack_waiting_next        = 1'b1;
                ack_value_next          = ACK_GO;
                conversion_divider_next = '0;
                start_next              = 1'b1;
              end
            end else if (is_end) begin
              if (life_state == LIFE_ACTIVE) begin
                life_state_next = LIFE_ENDED;
              end
            end else if (life_state == LIFE_ACTIVE) begin
              if (is_condis && port_ok) begin
                pending_kind_next  = (body_bytes[0] == CH_C) ? PEND_CON : PEND_DIS;
                pending_value_next = {3'b000, body_bytes[3][1:0]};
              end else if (is_lim && lim_ok) begin
                pending_kind_next = PEND_LIM;
                case (body_bytes[3])
                  CH_ONE:  pending_value_next = AMPS_16;
                  CH_TWO:  pending_value_next = AMPS_24;
                  default: pending_value_next = (body_bytes[4] == CH_EIGHT) ? AMPS_8 : AMPS_0;
                endcase
              end
            end
          end else if (body_length >= LEN_W'(BODY_MAX)) begin
            // Overlong body: drop the frame and wait for the next start mark.
            in_frame_next = 1'b0;
          end else begin
            body_write       = 1'b1;
            body_length_next = body_length + LEN_W'(1);
          end
        end
      end
    end else if (life_state == LIFE_ACTIVE) begin
      unique case (pending_kind)
        PEND_CON: begin
          if (port_bit != 3'b000 && (port_mask & port_bit) == 3'b000) begin
            port_mask_next   = port_mask | port_bit;
            ack_waiting_next = 1'b1;
            ack_value_next   = ACK_CON;
          end
        end
        PEND_DIS: begin
          if ((port_mask & port_bit) != 3'b000) begin
            port_mask_next   = port_mask & ~port_bit;
            ack_waiting_next = 1'b1;
            ack_value_next   = ACK_DIS;
          end
        end
        PEND_LIM: begin
          if (requested_amps != pending_value) begin
            requested_amps_next = pending_value;
            ack_waiting_next    = 1'b1;
            ack_value_next      = ACK_LIM;
          end
        end
        default: begin
        end
      endcase
      pending_kind_next = PEND_NONE;

      // An acknowledge still owed, from GO or from this tick, wins over status.
      if (ack_waiting_next) begin
        kind_next        = REPORT_ACK;
        ackn_next        = ack_value_next;
        ack_waiting_next = 1'b0;
      end else begin
        kind_next    = REPORT_STATUS;
        band_next    = thermal_band_char;
        reading_next = sensor_reading;
      end

      if (div_inc >= DIV_W'(CONVERSION_PERIOD)) begin
        conversion_divider_next = '0;
        start_next              = 1'b1;
      end else begin
        conversion_divider_next = div_inc;
      end
    end
  end

  assign eff_next = (requested_amps_next < thermal_limit_cap) ? requested_amps_next
                                                              : thermal_limit_cap;

  always_comb begin
    unique case (life_state_next)
      LIFE_WAITING: life_code_next = LC_WAITING;
      LIFE_ACTIVE:  life_code_next = LC_ACTIVE;
      LIFE_ENDED:   life_code_next = LC_ENDED;
      default:      life_code_next = LC_WAITING;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      life_state         <= LIFE_WAITING;
      port_mask          <= '0;
      pending_kind       <= PEND_NONE;
      pending_value      <= '0;
      ack_waiting        <= 1'b0;
      ack_value          <= ACK_GO;
      conversion_divider <= '0;
      requested_amps     <= '0;
      in_frame           <= 1'b0;
      body_length        <= '0;
    end else if (accept) begin
      life_state         <= life_state_next;
      port_mask          <= port_mask_next;
      pending_kind       <= pending_kind_next;
      pending_value      <= pending_value_next;
      ack_waiting        <= ack_waiting_next;
      ack_value          <= ack_value_next;
      conversion_divider <= conversion_divider_next;
      requested_amps     <= requested_amps_next;
      in_frame           <= in_frame_next;
      body_length        <= body_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && body_write) begin
      body_bytes[body_length[IDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      report_kind      <= kind_next;
      ack_number       <= ackn_next;
      band_out         <= band_next;
      reading_out      <= reading_next;
      ports_connected  <= port_mask_next;
      effective_limit  <= eff_next;
      start_conversion <= start_next;
      lifecycle        <= life_code_next;
    end
  end

endmodule
